### design/pmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and arithmetic helpers for the ARGB compositor.
package pmc_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PIX_W       = 32;
  localparam int CFG_W       = 8;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_BLEND = 2'd1,
    OP_COPY  = 2'd2
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                op;
    logic signed [11:0] dest_col;
    logic signed [11:0] dest_row;
    logic [31:0]        src_pixel;
    logic [7:0]         global_alpha;
    logic               last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] stored_pixel;
    logic        written;
    logic        in_bounds;
    logic        last_out;
  } out_item_t;

  // floor(x/255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  function automatic logic [7:0] mul_div255(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    p = {8'd0, c} * {8'd0, a};
    return div255(p);
  endfunction

endpackage
`default_nettype wire

### design/pmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port-write, registered-read RAM.
module pmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/pmc_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// Source-over of a premultiplied ARGB source onto a destination pixel.
module pmc_blend (
  input  wire logic [pmc_pkg::PIX_W-1:0] src,
  input  wire logic [pmc_pkg::PIX_W-1:0] dst,
  output logic      [pmc_pkg::PIX_W-1:0] pix
);
  import pmc_pkg::*;

  logic [7:0] inv;

  assign inv = 8'd255 - src[31:24];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix[k*8 +: 8] = src[k*8 +: 8] + mul_div255(dst[k*8 +: 8], inv);
    end
  end

endmodule
`default_nettype wire

### design/premultiplied_argb_compositor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Compositor top level: control sequencer, pixel store and output register.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   pmc_pkg::in_item_t
//   res      out        res_valid / res_stall     pmc_pkg::out_item_t
//   cfg      in         cfg_wr_en                 cfg_index, cfg_data
//
// Each item is accepted, then addressed with its source scaled during the
// store read, composited on the read data, then written back to the store
// with the result loaded into the output register. One item is in flight at a
// time; its store read-modify-write ends before another is taken. The next item is
// accepted while a result waits; a stalled result holds it in write-back.
// Synchronous reset clears control state, sets width and height to 128; store kept.
module premultiplied_argb_compositor_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire pmc_pkg::in_item_t         item,
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output pmc_pkg::out_item_t             res,
  input  wire logic                      cfg_wr_en,
  input  wire pmc_pkg::reg_idx_t         cfg_index,
  input  wire logic [pmc_pkg::CFG_W-1:0] cfg_data
);
  import pmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_CALC,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DIRECT,
    ACT_OVER
  } act_t;

  state_t              state;
  in_item_t            cur;
  logic [CFG_W-1:0]    scratch_width;
  logic [CFG_W-1:0]    scratch_height;

  logic                inb_q;
  logic [ADDR_W-1:0]   idx_q;
  act_t                act_q;
  logic [PIX_W-1:0]    srcs_q;
  out_item_t           done_q;

  logic [7:0]          w_eff;
  logic [7:0]          h_eff;
  logic                inb;
  logic [ADDR_W-1:0]   idx_full;
  logic [7:0]          scale_a;
  logic [7:0]          scale_c;
  logic [PIX_W-1:0]    srcs;
  act_t                act;

  logic [PIX_W-1:0]    rd_data;
  logic [PIX_W-1:0]    over_pix;
  logic [PIX_W-1:0]    result;
  logic                ram_we;
  logic                out_free;

  assign item_stall = (state != S_IDLE);
  assign out_free   = !res_valid || !res_stall;
  assign ram_we     = (state == S_DONE) && out_free && done_q.written;

  always_comb begin
    w_eff = (int'(scratch_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : scratch_width;
    h_eff = (int'(scratch_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : scratch_height;
    inb = !cur.dest_col[11] && !cur.dest_row[11] &&
          ({1'b0, cur.dest_col[10:0]} < {4'd0, w_eff}) &&
          ({1'b0, cur.dest_row[10:0]} < {4'd0, h_eff});
    idx_full = ADDR_W'(cur.dest_row[10:0]) * ADDR_W'(w_eff) +
               ADDR_W'(cur.dest_col[10:0]);
  end

  always_comb begin
    case (cur.op)
      OP_FILL: begin
        scale_a = 8'd255;
        scale_c = cur.src_pixel[31:24];
      end
      OP_BLEND: begin
        scale_a = cur.global_alpha;
        scale_c = cur.global_alpha;
      end
      default: begin
        scale_a = 8'd255;
        scale_c = 8'd255;
      end
    endcase
    srcs[31:24] = mul_div255(cur.src_pixel[31:24], scale_a);
    srcs[23:16] = mul_div255(cur.src_pixel[23:16], scale_c);
    srcs[15:8]  = mul_div255(cur.src_pixel[15:8], scale_c);
    srcs[7:0]   = mul_div255(cur.src_pixel[7:0], scale_c);

    act = ACT_NONE;
    if (inb) begin
      case (cur.op)
        OP_FILL: begin
          if (srcs[31:24] == 8'd255) begin
            act = ACT_DIRECT;
          end else if (srcs[31:24] != 8'd0) begin
            act = ACT_OVER;
          end
        end
        OP_BLEND: begin
          if (cur.global_alpha == 8'd0) begin
            act = ACT_NONE;
          end else if (srcs[31:24] == 8'd255) begin
            act = ACT_DIRECT;
          end else if (srcs[31:24] != 8'd0) begin
            act = ACT_OVER;
          end
        end
        OP_COPY: act = ACT_DIRECT;
        default: act = ACT_NONE;
      endcase
    end
  end

  pmc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_q),
    .wdata(done_q.stored_pixel),
    .re   (state == S_ADDR),
    .raddr(idx_full),
    .rdata(rd_data)
  );

  pmc_blend u_blend (
    .src(srcs_q),
    .dst(rd_data),
    .pix(over_pix)
  );

  always_comb begin
    case (act_q)
      ACT_DIRECT: result = srcs_q;
      ACT_OVER:   result = over_pix;
      default:    result = rd_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      scratch_width  <= 8'd128;
      scratch_height <= 8'd128;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_WIDTH:  scratch_width  <= cfg_data;
          REG_HEIGHT: scratch_height <= cfg_data;
          default: ;
        endcase
      end
      if ((state == S_DONE) && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          inb_q  <= inb;
          idx_q  <= idx_full;
          act_q  <= act;
          srcs_q <= srcs;
          state  <= S_CALC;
        end
        S_CALC: begin
          done_q.stored_pixel <= inb_q ? result : '0;
          done_q.written      <= (act_q != ACT_NONE);
          done_q.in_bounds    <= inb_q;
          done_q.last_out     <= cur.last_pixel;
          state               <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res   <= done_q;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> item_stall)
    else $error("item taken while busy");

  a_write_in_done: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_DONE) && done_q.in_bounds)
    else $error("store write outside write-back");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result without write-back");

  a_oob_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.in_bounds |-> !res.written && (res.stored_pixel == '0))
    else $error("out-of-bounds result not clean");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Compositor testbench: directed and random pixel transfers checked against a local pixel model.
module tb;
  import pmc_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int NUM_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_W [NUM_PHASES] = '{1, 128, 0, 12, 255, 200, 3, 0, 0, 128, 16};
  localparam int PHASE_H [NUM_PHASES] = '{1, 128, 9, 0, 255, 3, 200, 0, 0, 1, 16};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_item_t item = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_item_t res;
  logic cfg_wr_en = 1'b0;
  reg_idx_t cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  in_item_t pixel_queue[$];
  out_item_t expected_pixels[$];
  out_item_t due_result;
  logic [31:0] pixel_mem [STORE_DEPTH];
  bit seeded [STORE_DEPTH];
  int area_w = MAX_WIDTH;
  int area_h = MAX_HEIGHT;
  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int results_done = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  premultiplied_argb_compositor_top u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] scale255(input logic [7:0] c, input logic [7:0] a);
    return 8'((int'(c) * int'(a)) / 255);
  endfunction

  function automatic logic [31:0] src_over(input logic [7:0] a, r, g, b,
                                           input logic [31:0] dst);
    logic [7:0] inv;
    inv = 8'd255 - a;
    return {8'(a + scale255(dst[31:24], inv)), 8'(r + scale255(dst[23:16], inv)),
            8'(g + scale255(dst[15:8], inv)), 8'(b + scale255(dst[7:0], inv))};
  endfunction

  // -1 when the coordinate is outside the active area
  function automatic int store_index(input int col, input int row);
    if (col < 0 || row < 0 || col >= area_w || row >= area_h) return -1;
    return row * area_w + col;
  endfunction

  task automatic predict_composite(input in_item_t it);
    int idx;
    logic [31:0] d;
    logic [7:0] a, r, g, b;
    logic wr;
    out_item_t want;
    idx = store_index($signed(it.dest_col), $signed(it.dest_row));
    d = '0;
    wr = 1'b0;
    if (idx >= 0) begin
      d = pixel_mem[idx];
      {a, r, g, b} = it.src_pixel;
      case (it.op)
        OP_FILL: if (a != 8'd0) begin
          r = scale255(r, a);
          g = scale255(g, a);
          b = scale255(b, a);
          d = (a == 8'd255) ? {a, r, g, b} : src_over(a, r, g, b, d);
          wr = 1'b1;
        end
        OP_BLEND: if (it.global_alpha != 8'd0) begin
          if (it.global_alpha != 8'd255) begin
            a = scale255(a, it.global_alpha);
            r = scale255(r, it.global_alpha);
            g = scale255(g, it.global_alpha);
            b = scale255(b, it.global_alpha);
          end
          if (a != 8'd0) begin
            d = (a == 8'd255) ? {a, r, g, b} : src_over(a, r, g, b, d);
            wr = 1'b1;
          end
        end
        OP_COPY: begin
          d = it.src_pixel;
          wr = 1'b1;
        end
        default: ;
      endcase
      if (wr) pixel_mem[idx] = d;
    end
    want.stored_pixel = d;
    want.written = wr;
    want.in_bounds = (idx >= 0);
    want.last_out = it.last_pixel;
    expected_pixels.push_back(want);
  endtask

  function automatic in_item_t pix(input logic [1:0] op, input int col, input int row,
                                   input logic [31:0] src, input logic [7:0] ga,
                                   input bit last);
    in_item_t it;
    it.op = op_t'(op);
    it.dest_col = 12'(col);
    it.dest_row = 12'(row);
    it.src_pixel = src;
    it.global_alpha = ga;
    it.last_pixel = last;
    return it;
  endfunction

  // never read a store word before a copy has written it
  task automatic queue_item(input in_item_t it);
    int idx;
    idx = store_index($signed(it.dest_col), $signed(it.dest_row));
    if (idx >= 0) begin
      if (!seeded[idx]) it.op = OP_COPY;
      seeded[idx] = 1'b1;
    end
    pixel_queue.push_back(it);
  endtask

  task automatic queue_random_pixel();
    int sel, col, row;
    logic [1:0] op;
    logic [7:0] a, ga;
    sel = $urandom_range(0, 99);
    if (sel < 10 || area_w == 0 || area_h == 0) begin
      col = $signed(12'($urandom));
      row = $signed(12'($urandom));
    end else if (sel < 13) begin
      col = $urandom_range(0, 1) ? -1 : area_w;
      row = $urandom_range(0, area_h - 1);
    end else if (sel < 16) begin
      col = $urandom_range(0, area_w - 1);
      row = $urandom_range(0, 1) ? -1 : area_h;
    end else if (sel < 28) begin
      col = $urandom_range(0, area_w - 1);
      row = $urandom_range(0, area_h - 1);
    end else begin
      col = $urandom_range(0, (area_w < 12 ? area_w : 12) - 1);
      row = $urandom_range(0, (area_h < 12 ? area_h : 12) - 1);
    end
    sel = $urandom_range(0, 99);
    if (sel < 35) op = OP_FILL;
    else if (sel < 70) op = OP_BLEND;
    else if (sel < 90) op = OP_COPY;
    else op = OP_SPARE;
    sel = $urandom_range(0, 99);
    if (sel < 15) a = 8'd0;
    else if (sel < 30) a = 8'd255;
    else if (sel < 38) a = 8'($urandom_range(1, 3));
    else a = 8'($urandom_range(1, 254));
    sel = $urandom_range(0, 99);
    if (sel < 15) ga = 8'd0;
    else if (sel < 30) ga = 8'd255;
    else if (sel < 38) ga = 8'($urandom_range(1, 3));
    else ga = 8'($urandom_range(1, 254));
    queue_item(pix(op, col, row, {a, 24'($urandom)}, ga, $urandom_range(0, 7) == 0));
  endtask

  task automatic set_register(input reg_idx_t idx, input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_WIDTH) area_w = (value > MAX_WIDTH) ? MAX_WIDTH : value;
    else area_h = (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver: one transfer per accepting edge, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_composite(pixel_queue[0]);
        void'(pixel_queue.pop_front());
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (send_gaps_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 9);
          item_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          item_valid <= 1'b1;
          item <= pixel_queue[0];
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer, drive stall bursts and one long hold
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        results_done++;
        if (expected_pixels.size() == 0) begin
          $error("result transfer with nothing expected: %h", res);
          mismatches++;
        end else begin
          due_result = expected_pixels.pop_front();
          if (res.stored_pixel !== due_result.stored_pixel) begin
            $error("stored_pixel: expected %h, got %h", due_result.stored_pixel,
                   res.stored_pixel);
            mismatches++;
          end
          if (res.written !== due_result.written) begin
            $error("written: expected %b, got %b", due_result.written, res.written);
            mismatches++;
          end
          if (res.in_bounds !== due_result.in_bounds) begin
            $error("in_bounds: expected %b, got %b", due_result.in_bounds, res.in_bounds);
            mismatches++;
          end
          if (res.last_out !== due_result.last_out) begin
            $error("last_out: expected %b, got %b", due_result.last_out, res.last_out);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!hold_done && results_done >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (recv_stalls_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_item(pix(OP_COPY, 0, 0, 32'hFFFF_FFFF, 8'h00, 1'b0));
    queue_item(pix(OP_COPY, 127, 127, 32'h0000_0000, 8'hFF, 1'b1));
    queue_item(pix(OP_COPY, 0, 127, 32'h1234_5678, 8'h00, 1'b0));
    queue_item(pix(OP_COPY, 127, 0, 32'h80FF_00FF, 8'h00, 1'b0));
    queue_item(pix(OP_FILL, 0, 0, 32'h80FF_8040, 8'h00, 1'b0));
    queue_item(pix(OP_FILL, 0, 0, 32'h00FF_FFFF, 8'hFF, 1'b0));
    queue_item(pix(OP_FILL, 127, 127, 32'hFFAB_CDEF, 8'h00, 1'b1));
    queue_item(pix(OP_FILL, 127, 127, 32'h40C0_C0C0, 8'h10, 1'b0));
    queue_item(pix(OP_BLEND, 0, 127, 32'h8040_4040, 8'h00, 1'b0));
    queue_item(pix(OP_BLEND, 0, 127, 32'hFF10_2030, 8'hFF, 1'b0));
    queue_item(pix(OP_BLEND, 127, 0, 32'h01FF_FFFF, 8'd100, 1'b0));
    queue_item(pix(OP_BLEND, 127, 0, 32'h40FF_FFFF, 8'd200, 1'b0));
    queue_item(pix(OP_BLEND, 0, 0, 32'h7F7F_7F7F, 8'd254, 1'b1));
    queue_item(pix(OP_BLEND, 0, 0, 32'hFFFF_FFFF, 8'd1, 1'b0));
    queue_item(pix(OP_SPARE, 127, 127, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    queue_item(pix(OP_FILL, 128, 0, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    queue_item(pix(OP_BLEND, 0, 128, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    queue_item(pix(OP_COPY, -1, 5, 32'hDEAD_BEEF, 8'h00, 1'b0));
    queue_item(pix(OP_SPARE, 3, -1, 32'h0000_0000, 8'h00, 1'b0));
    queue_item(pix(OP_COPY, -2048, -2048, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    queue_item(pix(OP_FILL, 2047, 2047, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    queue_item(pix(OP_COPY, 64, 64, 32'hA5A5_5A5A, 8'h00, 1'b1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      send_gaps_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      recv_stalls_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      set_register(REG_WIDTH, (p == 7 || p == 8) ? $urandom_range(1, 128) : PHASE_W[p]);
      set_register(REG_HEIGHT, (p == 7 || p == 8) ? $urandom_range(1, 128) : PHASE_H[p]);
      repeat (ITEMS_PER_PHASE) queue_random_pixel();
    end

    wait_idle();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
design/pmc_pkg.sv
design/pmc_ram.sv
design/pmc_blend.sv
design/premultiplied_argb_compositor_top.sv
tb/tb.sv
